>>> sv/gated_exp_moving_average_top_macros.svh
// Assertion macros shared by the moving average block.
`ifndef GATED_EXP_MOVING_AVERAGE_TOP_MACROS_SVH
`define GATED_EXP_MOVING_AVERAGE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GEMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GEMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/gema_pkg.sv
// Types and fixed constants of the gated moving average block.
package gema_pkg;

    localparam int TIME_W     = 32;
    localparam int DECAY_W    = 16;
    localparam int CFG_CNT_W  = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Q0.16 value of one half.
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'h8000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_INTERVAL   = 3'd0,
        CFG_DECAY_FACTOR   = 3'd1,
        CFG_WARMUP_SAMPLES = 3'd2,
        CFG_MIN_SAMPLES    = 3'd3
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_POST  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage

>>> sv/gated_exp_moving_average_top.sv
// Sequence: a rejected request goes from CHECK straight to FIN, an exponential update
// passes CHECK, MUL, POST and FIN, and a warm-up update passes CHECK, MUL, POST, DIV and FIN.
// One request at a time: s_ready rises in the cycle after the result is registered, and a
// request holds the block in FIN while the output register is held unread.
// The states use a bit-serial shift-add multiplier (16 steps) and a restoring divider (one
// quotient bit per cycle) that takes its dividend from the multiplier's accumulator.
// Reset is synchronous for control, averaging state and configuration registers only.
`include "gated_exp_moving_average_top_macros.svh"

module gated_exp_moving_average_top #(
    parameter int SAMPLE_WIDTH    = 32,
    parameter int COUNT_WIDTH     = 16,
    parameter int DECAY_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  gema_pkg::cfg_index_t                cfg_index,
    input  logic [gema_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gema_pkg::TIME_W-1:0]         s_sample_time,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic signed [SAMPLE_WIDTH-1:0]      m_average,
    output logic                                m_settled
);
    import gema_pkg::*;

    localparam int NB        = (COUNT_WIDTH < CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;
    localparam int DIV_W     = NB + 1;
    localparam int MAG_W     = SAMPLE_WIDTH + NB;
    localparam int ACC_W     = SAMPLE_WIDTH + DECAY_W + 1;
    localparam int CMP_W     = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;
    localparam int STEPS_MAX = (SAMPLE_WIDTH > DECAY_W) ? SAMPLE_WIDTH : DECAY_W;
    localparam int STEP_W    = $clog2(STEPS_MAX);

    // Configuration registers
    logic [TIME_W-1:0]    min_interval_reg;
    logic [DECAY_W-1:0]   decay_reg;
    logic [CFG_CNT_W-1:0] warmup_reg;
    logic [CFG_CNT_W-1:0] min_samples_reg;

    // Averaging state
    logic [TIME_W-1:0]              last_time_reg, last_time_next;
    logic signed [SAMPLE_WIDTH-1:0] avg_reg, avg_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic                           settled_reg, settled_next;

    // Sequencer and datapath
    state_t                         state_reg, state_next;
    logic [TIME_W-1:0]              time_reg, time_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic                           ok_reg, ok_next;
    logic                           warm_reg, warm_next;
    logic                           neg_reg, neg_next;
    logic signed [ACC_W-1:0]        mcand_reg, mcand_next;
    logic [DECAY_W-1:0]             mult_reg, mult_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [DIV_W-1:0]               divisor_reg, divisor_next;
    logic [SAMPLE_WIDTH-1:0]        q_reg, q_next;
    logic [STEP_W-1:0]              step_reg, step_next;

    // Output register
    logic                           m_valid_reg, m_valid_next;
    logic                           m_accepted_reg, m_accepted_next;
    logic signed [SAMPLE_WIDTH-1:0] m_average_reg, m_average_next;
    logic                           m_settled_reg, m_settled_next;

    // Combinational terms
    logic [TIME_W:0]                gate_sum;
    logic                           gate_pass;
    logic                           warm_now;
    logic [NB-1:0]                  n_val;
    logic signed [SAMPLE_WIDTH:0]   diff;
    logic signed [ACC_W-1:0]        acc_sum;
    logic [ACC_W-1:0]               acc_mag;
    logic signed [ACC_W-1:0]        acc_scaled;
    logic [DIV_W:0]                 rem_shift;
    logic [DIV_W:0]                 rem_sub;
    logic                           q_bit;
    logic [SAMPLE_WIDTH-1:0]        result;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic                           settled_new;
    logic                           out_free;

    always_comb begin
        gate_sum    = {1'b0, last_time_reg} + {1'b0, min_interval_reg};
        gate_pass   = {1'b0, time_reg} >= gate_sum;
        warm_now    = CMP_W'(count_reg) < CMP_W'(warmup_reg);
        n_val       = count_reg[NB-1:0];
        diff        = {avg_reg[SAMPLE_WIDTH-1], avg_reg} - {x_reg[SAMPLE_WIDTH-1], x_reg};
        acc_sum     = acc_reg + (mult_reg[0] ? mcand_reg : ACC_W'(0));
        acc_mag     = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        acc_scaled  = acc_reg >>> DECAY_FRAC_BITS;
        rem_shift   = {rem_reg, q_reg[SAMPLE_WIDTH-1]};
        rem_sub     = rem_shift - {1'b0, divisor_reg};
        q_bit       = rem_shift >= {1'b0, divisor_reg};
        result      = neg_reg ? (~q_reg + 1'b1) : q_reg;
        count_inc   = (&count_reg) ? count_reg : count_reg + 1'b1;
        settled_new = CMP_W'(count_inc) > CMP_W'(min_samples_reg);
        out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next      = state_reg;
        time_next       = time_reg;
        x_next          = x_reg;
        ok_next         = ok_reg;
        warm_next       = warm_reg;
        neg_next        = neg_reg;
        mcand_next      = mcand_reg;
        mult_next       = mult_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        q_next          = q_reg;
        step_next       = step_reg;
        last_time_next  = last_time_reg;
        avg_next        = avg_reg;
        count_next      = count_reg;
        settled_next    = settled_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_accepted_next = m_accepted_reg;
        m_average_next  = m_average_reg;
        m_settled_next  = m_settled_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    time_next  = s_sample_time;
                    x_next     = s_sample_value;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                ok_next      = gate_pass;
                warm_next    = warm_now;
                divisor_next = DIV_W'(n_val) + DIV_W'(1);
                step_next    = STEP_W'(DECAY_W - 1);
                if (!gate_pass) begin
                    state_next = ST_FIN;
                end else if (warm_now) begin
                    // Running mean numerator: avg * n + x.
                    mcand_next = ACC_W'(avg_reg);
                    mult_next  = DECAY_W'(n_val);
                    acc_next   = ACC_W'(x_reg);
                    state_next = ST_MUL;
                end else begin
                    mcand_next = ACC_W'(diff);
                    mult_next  = decay_reg;
                    acc_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next   = acc_sum;
                mcand_next = mcand_reg <<< 1;
                mult_next  = mult_reg >> 1;
                step_next  = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (warm_reg) begin
                    // The high part of the magnitude is always below the divisor, so
                    // only the low SAMPLE_WIDTH quotient bits need to be developed.
                    neg_next   = acc_reg[ACC_W-1];
                    rem_next   = DIV_W'(acc_mag[MAG_W-1:SAMPLE_WIDTH]);
                    q_next     = acc_mag[SAMPLE_WIDTH-1:0];
                    step_next  = STEP_W'(SAMPLE_WIDTH - 1);
                    state_next = ST_DIV;
                end else begin
                    neg_next   = 1'b0;
                    q_next     = x_reg + acc_scaled[SAMPLE_WIDTH-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                q_next    = {q_reg[SAMPLE_WIDTH-2:0], q_bit};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_accepted_next = ok_reg;
                    if (ok_reg) begin
                        last_time_next = time_reg;
                        avg_next       = result;
                        count_next     = count_inc;
                        settled_next   = settled_new;
                        m_average_next = result;
                        m_settled_next = settled_new;
                    end else begin
                        m_average_next = avg_reg;
                        m_settled_next = settled_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            min_interval_reg <= '0;
            decay_reg        <= DECAY_RESET;
            warmup_reg       <= '0;
            min_samples_reg  <= '0;
            last_time_reg    <= '0;
            avg_reg          <= '0;
            count_reg        <= '0;
            settled_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            last_time_reg <= last_time_next;
            avg_reg       <= avg_next;
            count_reg     <= count_next;
            settled_reg   <= settled_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MIN_INTERVAL:   min_interval_reg <= cfg_wdata[TIME_W-1:0];
                    CFG_DECAY_FACTOR:   decay_reg        <= cfg_wdata[DECAY_W-1:0];
                    CFG_WARMUP_SAMPLES: warmup_reg       <= cfg_wdata[CFG_CNT_W-1:0];
                    CFG_MIN_SAMPLES:    min_samples_reg  <= cfg_wdata[CFG_CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        time_reg       <= time_next;
        x_reg          <= x_next;
        ok_reg         <= ok_next;
        warm_reg       <= warm_next;
        neg_reg        <= neg_next;
        mcand_reg      <= mcand_next;
        mult_reg       <= mult_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        q_reg          <= q_next;
        step_reg       <= step_next;
        m_accepted_reg <= m_accepted_next;
        m_average_reg  <= m_average_next;
        m_settled_reg  <= m_settled_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_accepted = m_accepted_reg;
    assign m_average  = m_average_reg;
    assign m_settled  = m_settled_reg;

    // The average may only move when an accepted request is retired.
    `GEMA_ASSERT_NEXT(a_avg_held, (state_reg != ST_FIN) || !ok_reg || !out_free, $stable(avg_reg), "average changed outside an accepted update")
    // The sample count never falls.
    `GEMA_ASSERT_NEXT(a_count_monotonic, 1'b1, count_reg >= $past(count_reg), "accepted count decreased")
    // The partial remainder must stay below the divisor throughout the division.
    `GEMA_ASSERT_SAME(a_rem_bound, state_reg == ST_DIV, rem_reg < divisor_reg, "divider remainder out of range")
    // Settled implies at least one accepted sample.
    `GEMA_ASSERT_SAME(a_settled_count, settled_reg, count_reg != '0, "settled without any accepted sample")

endmodule
